@@ sv/in_flight_limiter_two_priority_unit_macros.svh @@
// Assertion helpers for the limiter RTL.
`ifndef IN_FLIGHT_LIMITER_TWO_PRIORITY_UNIT_MACROS_SVH
`define IN_FLIGHT_LIMITER_TWO_PRIORITY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define IFL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define IFL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ifl_pkg.sv @@
`default_nettype none

package ifl_pkg;

    localparam int ID_W     = 16;
    localparam int GROUP_W  = 8;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [ID_W-1:0]    id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Item actions
    localparam logic ACT_SUBMIT   = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HANDED_ON  = 3'd4;

    // Register indexes
    localparam logic REG_LIMIT_ENABLED = 1'b0;
    localparam logic REG_MAX_IN_FLIGHT = 1'b1;

    // Where a result takes its task from
    localparam logic [1:0] SRC_INPUT  = 2'd0;
    localparam logic [1:0] SRC_HIGH   = 2'd1;
    localparam logic [1:0] SRC_NORMAL = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

endpackage

`default_nettype wire

@@ sv/ifl_ram.sv @@
`default_nettype none

module ifl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ sv/in_flight_limiter_two_priority_unit.sv @@
// Channel  | Direction | Handshake                 | Beat payload
// ---------+-----------+---------------------------+------------------------------------------
// in       | input     | i_in_valid / o_in_stall   | action, task_id, group, urgent
// out      | output    | o_out_valid / i_out_stall | status, out_task_id, out_group,
//          |           |                           | in_flight
// config   | input     | APB (psel, penable, ...)  | 0x0 limit_enabled, 0x4 max_in_flight
//
// Every input beat yields one output beat: the decision and the queue RAM read happen
// at accept, and the result moves from stage 1 into the output register once that
// register is free or draining. One beat per cycle is sustained; the in stage stalls
// only while its result cannot move into the output register. Reset is synchronous,
// active low, clears the count, fill levels, pointers, valid flags and max_in_flight and
// sets limit_enabled; queue RAM is left alone since only pushed entries are ever popped.
`default_nettype none

`include "in_flight_limiter_two_priority_unit_macros.svh"

module in_flight_limiter_two_priority_unit
    import ifl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_action,
    input  wire logic [ID_W-1:0]     i_task_id,
    input  wire logic [GROUP_W-1:0]  i_group,
    input  wire logic                i_urgent,

    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [ID_W-1:0]          o_out_task_id,
    output logic [GROUP_W-1:0]       o_out_group,
    output logic [COUNT_W-1:0]       o_in_flight,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic               r_limit_en;
    logic [COUNT_W-1:0] r_max;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_en <= 1'b1;
            r_max      <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LIMIT_ENABLED: r_limit_en <= pwdata[0];
                REG_MAX_IN_FLIGHT: r_max      <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LIMIT_ENABLED: prdata = {31'd0, r_limit_en};
            REG_MAX_IN_FLIGHT: prdata = {{(32-COUNT_W){1'b0}}, r_max};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Queue bookkeeping: count, fill levels and pointers in flops,
    // queue entries in two RAMs
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] r_count,     n_count;
    logic [FILL_W-1:0]  r_high_fill, n_high_fill;
    logic [FILL_W-1:0]  r_norm_fill, n_norm_fill;
    logic [PTR_W-1:0]   r_high_rd,   n_high_rd;
    logic [PTR_W-1:0]   r_high_wr,   n_high_wr;
    logic [PTR_W-1:0]   r_norm_rd,   n_norm_rd;
    logic [PTR_W-1:0]   r_norm_wr,   n_norm_wr;

    // Stage 1: decision made, RAM read in progress
    logic                r_s1_valid;
    logic [STATUS_W-1:0] r_s1_status, n_s1_status;
    logic [COUNT_W-1:0]  r_s1_count;
    logic [1:0]          r_s1_src,    n_s1_src;
    t_entry              r_s1_entry,  n_s1_entry;

    // Output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    t_entry              r_out_entry;
    logic [COUNT_W-1:0]  r_out_count;

    logic   in_acc;
    logic   s1_move;
    logic   at_cap;
    logic   push_high, push_norm, pop_high, pop_norm;
    t_entry in_entry;
    t_entry high_rd_data, norm_rd_data;

    // s1 advances whenever the output register is free or being drained
    assign s1_move    = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~s1_move;
    assign in_acc     = i_in_valid & ~o_in_stall;

    assign in_entry.group = i_group;
    assign in_entry.id    = i_task_id;
    assign at_cap         = (r_max != '0) && (r_count >= r_max);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_count     = r_count;
        n_s1_status = ST_DISPATCHED;
        n_s1_src    = SRC_INPUT;
        n_s1_entry  = '0;
        push_high   = 1'b0;
        push_norm   = 1'b0;
        pop_high    = 1'b0;
        pop_norm    = 1'b0;

        if (i_action == ACT_SUBMIT) begin
            if (!r_limit_en) begin
                // pass through, not counted
                n_s1_entry = in_entry;
            end else if (at_cap) begin
                // park the task in its queue, or drop it when full
                if (i_urgent) begin
                    push_high   = (r_high_fill != FILL_FULL);
                    n_s1_status = push_high ? ST_QUEUED : ST_DROPPED;
                end else begin
                    push_norm   = (r_norm_fill != FILL_FULL);
                    n_s1_status = push_norm ? ST_QUEUED : ST_DROPPED;
                end
            end else begin
                n_s1_entry = in_entry;
                if (r_count != COUNT_TOP) begin
                    n_count = r_count + COUNT_W'(1);
                end
            end
        end else begin
            n_s1_status = ST_FREED;
            if (r_limit_en) begin
                if (((r_high_fill != '0) || (r_norm_fill != '0)) && (r_count <= r_max)) begin
                    // hand the slot on, high queue first
                    n_s1_status = ST_HANDED_ON;
                    if (r_high_fill != '0) begin
                        pop_high = 1'b1;
                        n_s1_src = SRC_HIGH;
                    end else begin
                        pop_norm = 1'b1;
                        n_s1_src = SRC_NORMAL;
                    end
                end else if (r_count != '0) begin
                    n_count = r_count - COUNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_high_fill = r_high_fill;
        n_norm_fill = r_norm_fill;
        n_high_rd   = r_high_rd;
        n_high_wr   = r_high_wr;
        n_norm_rd   = r_norm_rd;
        n_norm_wr   = r_norm_wr;
        if (push_high) begin
            n_high_wr   = ptr_inc(r_high_wr);
            n_high_fill = r_high_fill + FILL_W'(1);
        end
        if (pop_high) begin
            n_high_rd   = ptr_inc(r_high_rd);
            n_high_fill = r_high_fill - FILL_W'(1);
        end
        if (push_norm) begin
            n_norm_wr   = ptr_inc(r_norm_wr);
            n_norm_fill = r_norm_fill + FILL_W'(1);
        end
        if (pop_norm) begin
            n_norm_rd   = ptr_inc(r_norm_rd);
            n_norm_fill = r_norm_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_high_fill <= '0;
            r_norm_fill <= '0;
            r_high_rd   <= '0;
            r_high_wr   <= '0;
            r_norm_rd   <= '0;
            r_norm_wr   <= '0;
        end else if (in_acc) begin
            r_count     <= n_count;
            r_high_fill <= n_high_fill;
            r_norm_fill <= n_norm_fill;
            r_high_rd   <= n_high_rd;
            r_high_wr   <= n_high_wr;
            r_norm_rd   <= n_norm_rd;
            r_norm_wr   <= n_norm_wr;
        end
    end

    // Reads happen only at accept, so read data holds while s1 waits
    ifl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_high_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc & push_high),
        .i_wr_addr (r_high_wr),
        .i_wr_data (in_entry),
        .i_rd_en   (in_acc & pop_high),
        .i_rd_addr (r_high_rd),
        .o_rd_data (high_rd_data)
    );

    ifl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_norm_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc & push_norm),
        .i_wr_addr (r_norm_wr),
        .i_wr_data (in_entry),
        .i_rd_en   (in_acc & pop_norm),
        .i_rd_addr (r_norm_rd),
        .o_rd_data (norm_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1 and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status <= n_s1_status;
            r_s1_count  <= n_count;
            r_s1_src    <= n_s1_src;
            r_s1_entry  <= n_s1_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status <= r_s1_status;
            r_out_count  <= r_s1_count;
            case (r_s1_src)
                SRC_HIGH:   r_out_entry <= high_rd_data;
                SRC_NORMAL: r_out_entry <= norm_rd_data;
                default:    r_out_entry <= r_s1_entry;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_task_id = r_out_entry.id;
    assign o_out_group   = r_out_entry.group;
    assign o_in_flight   = r_out_count;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IFL_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1,
        (r_high_fill <= FILL_FULL) && (r_norm_fill <= FILL_FULL),
        "queue fill level above depth")
    `IFL_ASSERT_IMP(a_empty_ptrs, i_clk, i_rst_n, (r_high_fill == '0),
        (r_high_wr == r_high_rd), "high queue empty with pointers apart")
    `IFL_ASSERT_IMP(a_no_idle_stall, i_clk, i_rst_n, !r_s1_valid, !o_in_stall,
        "input stalled with empty stage")
    `IFL_ASSERT_NXT(a_disabled_count, i_clk, i_rst_n, in_acc && !r_limit_en,
        (r_count == $past(r_count)), "count changed with limit disabled")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;
    import ifl_pkg::*;

    localparam int QDEPTH         = 16;
    localparam int IDLE_MAX       = 17;
    localparam int DRAIN_PAUSE    = 4;      // pipeline is two stages deep
    localparam int WATCHDOG_LIMIT = 400;    // quiet cycles before giving up
    localparam int RANDOM_PHASES  = 12;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [GROUP_W-1:0]  group;
        logic [COUNT_W-1:0]  in_flight;
    } t_result;

    typedef enum logic {ROW_BEAT, ROW_WRITE} t_row_kind;

    // One line of the directed stimulus: either a beat or a register write.
    typedef struct {
        t_row_kind          kind;
        logic               act;
        logic [ID_W-1:0]    id;
        logic [GROUP_W-1:0] grp;
        logic               hi;
        logic               reg_sel;
        logic [31:0]        value;
        bit                 has_exp;
        t_result            exp;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_action = ACT_SUBMIT;
    logic [ID_W-1:0]     i_task_id = '0;
    logic [GROUP_W-1:0]  i_group = '0;
    logic                i_urgent = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_out_task_id;
    logic [GROUP_W-1:0]  o_out_group;
    logic [COUNT_W-1:0]  o_in_flight;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Shadow of the limiter: registers, count and both priority queues.
    logic                lim_en = 1'b1;
    logic [COUNT_W-1:0]  lim_max = '0;
    logic [COUNT_W-1:0]  flight_cnt = '0;
    t_entry              high_q[$];
    t_entry              norm_q[$];

    t_result             pending_results[$];
    t_row                plan[$];

    bit                  tx_idle_on = 1'b1;
    bit                  rx_idle_on = 1'b1;
    int unsigned         rx_hold = 0;
    int unsigned         mismatches = 0;
    int unsigned         beats_sent = 0;
    int unsigned         results_seen = 0;
    int unsigned         settings_used = 0;
    int unsigned         status_tally[8];
    int unsigned         quiet_cycles = 0;

    in_flight_limiter_two_priority_unit #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_task_id        (i_task_id),
        .i_group          (i_group),
        .i_urgent         (i_urgent),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_out_task_id    (o_out_task_id),
        .o_out_group      (o_out_group),
        .o_in_flight      (o_in_flight),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Work out the result of one accepted beat and advance the shadow state.
    function automatic t_result predict_admission(input logic act, input logic [ID_W-1:0] id,
                                                  input logic [GROUP_W-1:0] grp,
                                                  input logic hi);
        t_result r;
        t_entry  e;
        r = '0;
        r.status = ST_DISPATCHED;
        if (act == ACT_SUBMIT) begin
            if (!lim_en) begin
                // limit off: dispatch, leave the count alone
                r.id    = id;
                r.group = grp;
            end else if (lim_max != '0 && flight_cnt >= lim_max) begin
                // held back: park in the chosen queue, drop when it is full
                e.id    = id;
                e.group = grp;
                if (hi ? high_q.size() < QDEPTH : norm_q.size() < QDEPTH) begin
                    if (hi) high_q.push_back(e);
                    else    norm_q.push_back(e);
                    r.status = ST_QUEUED;
                end else begin
                    r.status = ST_DROPPED;
                end
            end else begin
                // saturate the count at its top value
                if (flight_cnt != COUNT_TOP) flight_cnt++;
                r.id    = id;
                r.group = grp;
            end
        end else begin
            if (!lim_en) begin
                r.status = ST_FREED;
            end else if ((high_q.size() != 0 || norm_q.size() != 0) && flight_cnt <= lim_max) begin
                // hand the slot on, high queue first; the count stays
                if (high_q.size() != 0) begin
                    e = high_q[0];
                    high_q.delete(0);
                end else begin
                    e = norm_q[0];
                    norm_q.delete(0);
                end
                r.status = ST_HANDED_ON;
                r.id     = e.id;
                r.group  = e.group;
            end else begin
                if (flight_cnt != '0) flight_cnt--;
                r.status = ST_FREED;
            end
        end
        r.in_flight = flight_cnt;
        return r;
    endfunction

    function automatic void check_field(input string what, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
        end
    endfunction

    function automatic void beat_row(input logic act, input logic [ID_W-1:0] id,
                                     input logic [GROUP_W-1:0] grp, input logic hi);
        t_row row;
        row         = '{kind: ROW_BEAT, default: '0};
        row.act     = act;
        row.id      = id;
        row.grp     = grp;
        row.hi      = hi;
        plan.push_back(row);
    endfunction

    // Beat whose result is plain to see; the typed value replaces the prediction.
    function automatic void beat_row_exp(input logic act, input logic [ID_W-1:0] id,
                                         input logic [GROUP_W-1:0] grp, input logic hi,
                                         input logic [STATUS_W-1:0] st,
                                         input logic [ID_W-1:0] oid,
                                         input logic [GROUP_W-1:0] ogrp,
                                         input logic [COUNT_W-1:0] cnt);
        beat_row(act, id, grp, hi);
        plan[plan.size()-1].has_exp = 1'b1;
        plan[plan.size()-1].exp     = '{st, oid, ogrp, cnt};
    endfunction

    function automatic void write_row(input logic sel, input logic [31:0] value);
        t_row row;
        row         = '{kind: ROW_WRITE, default: '0};
        row.reg_sel = sel;
        row.value   = value;
        plan.push_back(row);
    endfunction

    // Drive one beat after a random gap, hold it until accepted, then predict.
    task automatic send_beat(input logic act, input logic [ID_W-1:0] id,
                             input logic [GROUP_W-1:0] grp, input logic hi,
                             input bit has_exp, input t_result typed);
        int unsigned gap;
        t_result     r;
        gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_task_id    <= id;
        i_group      <= grp;
        i_urgent     <= hi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = predict_admission(act, id, grp, hi);
        pending_results.push_back(has_exp ? typed : r);
        beats_sent++;
    endtask

    // Drop valid and let every outstanding result come back before touching registers.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_LIMIT_ENABLED) lim_en = value[0];
        else                          lim_max = value[COUNT_W-1:0];
        settings_used++;
        @(posedge i_clk);
    endtask

    task automatic read_reg(input logic sel, input logic [31:0] want, input logic [31:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        check_field(sel == REG_LIMIT_ENABLED ? "limit_enabled readback" : "max_in_flight readback",
                    want & mask, prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reprogram both registers, then fire a burst of random submits and completions.
    task automatic random_phase(input int unsigned n_beats, input logic en,
                                input logic [COUNT_W-1:0] mx);
        int unsigned submit_pct;
        logic [31:0] rnd;
        wait_drained();
        write_reg(REG_LIMIT_ENABLED, {31'b0, en});
        write_reg(REG_MAX_IN_FLIGHT, {16'b0, mx});
        read_reg(REG_MAX_IN_FLIGHT, {16'b0, mx}, 32'h0000_FFFF);
        submit_pct = $urandom_range(35, 80);
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        repeat (n_beats) begin
            rnd = $urandom;
            send_beat(($urandom_range(1, 100) > submit_pct) ? ACT_COMPLETE : ACT_SUBMIT,
                      rnd[15:0], rnd[23:16], rnd[24], 1'b0, '0);
        end
    endtask

    // Output side: check each result beat in order and stall at random.
    always @(posedge i_clk) begin : out_monitor
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                status_tally[o_status]++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, status %0d",
                             $time, o_status);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    check_field("status", want.status, o_status);
                    check_field("out_task_id", want.id, o_out_task_id);
                    check_field("out_group", want.group, o_out_group);
                    check_field("in_flight", want.in_flight, o_in_flight);
                end
                rx_hold = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            end
            // hold the stall while rx_hold is nonzero, count down only while a beat is waiting
            if (rx_hold != 0) begin
                i_out_stall <= 1'b1;
                if (o_out_valid) rx_hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        logic [31:0]         rnd;
        logic                en;
        logic [COUNT_W-1:0]  mx;

        // Directed rows. Reset leaves the limit on with no cap.
        beat_row_exp(ACT_SUBMIT,   16'hFFFF, 8'hFF, 1'b0, ST_DISPATCHED, 16'hFFFF, 8'hFF, 16'd1);
        beat_row_exp(ACT_SUBMIT,   16'h0000, 8'h00, 1'b1, ST_DISPATCHED, 16'h0000, 8'h00, 16'd2);
        // completion payload is ignored and never echoed
        beat_row_exp(ACT_COMPLETE, 16'hAAAA, 8'h55, 1'b1, ST_FREED, 16'h0, 8'h0, 16'd1);
        beat_row_exp(ACT_COMPLETE, 16'h0000, 8'h00, 1'b0, ST_FREED, 16'h0, 8'h0, 16'd0);
        // completion with the count already at zero
        beat_row_exp(ACT_COMPLETE, 16'h5A5A, 8'hA5, 1'b0, ST_FREED, 16'h0, 8'h0, 16'd0);
        // cap of one: park one normal and one high task, high one leaves first
        write_row(REG_MAX_IN_FLIGHT, 32'd1);
        beat_row_exp(ACT_SUBMIT,   16'h1234, 8'h12, 1'b0, ST_DISPATCHED, 16'h1234, 8'h12, 16'd1);
        beat_row_exp(ACT_SUBMIT,   16'h5555, 8'hAA, 1'b0, ST_QUEUED, 16'h0, 8'h0, 16'd1);
        beat_row_exp(ACT_SUBMIT,   16'hAAAA, 8'h55, 1'b1, ST_QUEUED, 16'h0, 8'h0, 16'd1);
        beat_row_exp(ACT_COMPLETE, 16'h0000, 8'h00, 1'b0, ST_HANDED_ON, 16'hAAAA, 8'h55, 16'd1);
        beat_row_exp(ACT_COMPLETE, 16'hFFFF, 8'hFF, 1'b1, ST_HANDED_ON, 16'h5555, 8'hAA, 16'd1);
        beat_row_exp(ACT_COMPLETE, 16'h0000, 8'h00, 1'b0, ST_FREED, 16'h0, 8'h0, 16'd0);
        // no cap again: everything dispatches
        write_row(REG_MAX_IN_FLIGHT, 32'd0);
        beat_row_exp(ACT_SUBMIT,   16'h0F0F, 8'hF0, 1'b0, ST_DISPATCHED, 16'h0F0F, 8'hF0, 16'd1);
        beat_row_exp(ACT_SUBMIT,   16'hF0F0, 8'h0F, 1'b1, ST_DISPATCHED, 16'hF0F0, 8'h0F, 16'd2);
        beat_row_exp(ACT_SUBMIT,   16'h00FF, 8'h80, 1'b0, ST_DISPATCHED, 16'h00FF, 8'h80, 16'd3);
        // lower the cap below the count: completions decrement before handing on
        write_row(REG_MAX_IN_FLIGHT, 32'd2);
        beat_row(ACT_SUBMIT,   16'h8000, 8'h01, 1'b1);
        beat_row(ACT_COMPLETE, 16'h0000, 8'h00, 1'b0);
        beat_row(ACT_COMPLETE, 16'h0000, 8'h00, 1'b0);
        // limit off: pass through, count frozen
        write_row(REG_LIMIT_ENABLED, 32'd0);
        beat_row_exp(ACT_SUBMIT,   16'hBEEF, 8'h3C, 1'b1, ST_DISPATCHED, 16'hBEEF, 8'h3C, 16'd2);
        beat_row_exp(ACT_COMPLETE, 16'h0000, 8'h00, 1'b0, ST_FREED, 16'h0, 8'h0, 16'd2);
        // widest cap
        write_row(REG_LIMIT_ENABLED, 32'd1);
        write_row(REG_MAX_IN_FLIGHT, 32'h0000_FFFF);
        beat_row(ACT_SUBMIT,   16'h7FFF, 8'h7F, 1'b0);
        beat_row(ACT_COMPLETE, 16'h0000, 8'h00, 1'b0);
        beat_row(ACT_COMPLETE, 16'h0000, 8'h00, 1'b0);
        beat_row(ACT_COMPLETE, 16'h0000, 8'h00, 1'b0);

        // Hold reset, then release it once.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_reg(REG_LIMIT_ENABLED, 32'd1, 32'h0000_0001);
        read_reg(REG_MAX_IN_FLIGHT, 32'd0, 32'h0000_FFFF);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(plan[i].reg_sel, plan[i].value);
            end else begin
                send_beat(plan[i].act, plan[i].id, plan[i].grp, plan[i].hi,
                          plan[i].has_exp, plan[i].exp);
            end
        end

        // Random phases: the first five pin fixed settings, the rest are drawn.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            rnd = $urandom;
            en  = 1'b1;
            case (p)
                0: mx = 16'd1;
                1: mx = 16'd0;
                2: begin
                    en = 1'b0;
                    mx = rnd[15:0];
                end
                3: mx = COUNT_TOP;
                4: mx = 16'd2;
                default: begin
                    en = (rnd[31:29] != 3'd0);
                    case (rnd[28:26])
                        3'd0:    mx = 16'd0;
                        3'd1:    mx = COUNT_TOP;
                        3'd2:    mx = rnd[15:0];
                        default: mx = 16'($urandom_range(1, 6));
                    endcase
                end
            endcase
            random_phase($urandom_range(120, 150), en, mx);
        end

        wait_drained();
        repeat (2 * DRAIN_PAUSE) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end

        $display("Ran %0d input beats, %0d results, %0d register writes",
                 beats_sent, results_seen, settings_used);
        $display("dispatched %0d, queued %0d, dropped %0d, freed %0d, handed on %0d",
                 status_tally[ST_DISPATCHED], status_tally[ST_QUEUED],
                 status_tally[ST_DROPPED], status_tally[ST_FREED],
                 status_tally[ST_HANDED_ON]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/ifl_pkg.sv
sv/ifl_ram.sv
sv/in_flight_limiter_two_priority_unit.sv
sim/tb_top.sv
